[hw/rtl/mesf_pkg.sv]
`default_nettype none

package mesf_pkg;

  // window geometry
  localparam int WINDOW   = 5;
  localparam int NumCh    = 2;
  localparam int SlotW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WinDepth = NumCh * WINDOW;
  localparam int WinAddrW = $clog2(WinDepth);
  localparam int MedIdx   = WINDOW / 2;

  // field widths and fixed-point formats
  localparam int CodeW  = 12;
  localparam int AlphaW = 17;
  localparam int FracW  = 16;
  localparam int AvgW   = CodeW + FracW;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [AlphaW-1:0] AlphaOne   = AlphaW'(1 << FracW);
  localparam logic [AlphaW-1:0] AlphaReset = AlphaW'(6554);
  localparam logic [AvgW-1:0]   AvgMax     = AvgW'(((1 << CodeW) - 1) << FracW);
  localparam logic [SlotW-1:0]  LastIdx    = SlotW'(WINDOW - 1);

  // item kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_EMA_ALPHA = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_MUL,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic                wr_en;
    logic [WinAddrW-1:0] wr_addr;
    logic [CodeW-1:0]    wr_data;
    logic                rd_en;
    logic [WinAddrW-1:0] rd_addr;
  } win_ctl_t;

  typedef struct packed {
    logic clr;
    logic ins;
  } sort_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic clear;
    logic mul_en;
    logic wr_en;
    logic ch;
  } ema_ctl_t;

  // each channel owns WINDOW consecutive entries of the window memory
  function automatic logic [WinAddrW-1:0] win_addr(input logic ch,
                                                   input logic [SlotW-1:0] slot);
    win_addr = (ch ? WinAddrW'(WINDOW) : '0) + WinAddrW'(slot);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mesf_if.sv]
`default_nettype none

// sample channel
interface mesf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       channel;
  logic [mesf_pkg::CodeW-1:0] sample_code;

  modport source (output valid, kind, channel, sample_code, input ready);
  modport sink   (input valid, kind, channel, sample_code, output ready);
endinterface

// filtered result channel
interface mesf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       out_channel;
  logic [mesf_pkg::CodeW-1:0] median_code;
  logic [mesf_pkg::AvgW-1:0]  filtered_value;

  modport source (output valid, out_channel, median_code, filtered_value, input ready);
  modport sink   (input valid, out_channel, median_code, filtered_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/mesf_window.sv]
`default_nettype none

module mesf_window (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mesf_pkg::win_ctl_t         ctl,
  output logic                            rd_vld,
  output logic [mesf_pkg::CodeW-1:0]      rd_code
);
  import mesf_pkg::*;

  logic [CodeW-1:0]    win_mem [WinDepth];
  logic [WinDepth-1:0] written_r;
  logic [CodeW-1:0]    rdata_r;
  logic                rwritten_r;
  logic                rvld_r;

  // window memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      win_mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= win_mem[ctl.rd_addr];
    end
  end

  // written flags stand in for the zero fill after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= '0;
      rwritten_r <= 1'b0;
      rvld_r     <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        written_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rwritten_r <= written_r[ctl.rd_addr];
      end
      rvld_r <= ctl.rd_en;
    end
  end

  assign rd_vld  = rvld_r;
  assign rd_code = rwritten_r ? rdata_r : '0;

endmodule

`default_nettype wire

[hw/rtl/mesf_sorter.sv]
`default_nettype none

module mesf_sorter (
  input  wire logic                       clk,
  input  wire mesf_pkg::sort_ctl_t        ctl,
  input  wire logic [mesf_pkg::CodeW-1:0] code,
  output logic [mesf_pkg::CodeW-1:0]      median
);
  import mesf_pkg::*;

  logic [CodeW-1:0] srt_r   [WINDOW];
  logic [CodeW-1:0] srt_nxt [WINDOW];

  // insertion sort, one code per cycle; empty slots hold the largest code
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      if (ctl.clr) begin
        srt_nxt[i] = '1;
      end else if (ctl.ins) begin
        if (srt_r[i] <= code) begin
          srt_nxt[i] = srt_r[i];
        end else if (i == 0) begin
          srt_nxt[i] = code;
        end else if (srt_r[(i == 0) ? 0 : i - 1] <= code) begin
          srt_nxt[i] = code;
        end else begin
          srt_nxt[i] = srt_r[(i == 0) ? 0 : i - 1];
        end
      end else begin
        srt_nxt[i] = srt_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW; i++) begin
      srt_r[i] <= srt_nxt[i];
    end
  end

  assign median = srt_r[MedIdx];

endmodule

`default_nettype wire

[hw/rtl/mesf_ema.sv]
`default_nettype none

module mesf_ema (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mesf_pkg::ema_ctl_t          ctl,
  input  wire logic [mesf_pkg::AlphaW-1:0] alpha,
  input  wire logic [mesf_pkg::CodeW-1:0]  median,
  output logic [mesf_pkg::AvgW-1:0]        avg_new
);
  import mesf_pkg::*;

  localparam int NewW = AlphaW + CodeW;
  localparam int OldW = AlphaW + AvgW;

  logic [AvgW-1:0]   avg_mem [NumCh];
  logic [NumCh-1:0]  loaded_r;
  logic [AvgW-1:0]   avg_rd_r;
  logic              ld_r;
  logic [NewW-1:0]   p_new_r;
  logic [OldW-1:0]   p_old_r;
  logic [AlphaW-1:0] alpha_eff;
  logic [AlphaW-1:0] alpha_inv;
  logic [OldW-1:0]   old_rnd;
  logic [NewW:0]     blend;

  // alpha above one counts as one
  assign alpha_eff = (alpha > AlphaOne) ? AlphaOne : alpha;
  assign alpha_inv = AlphaOne - alpha_eff;

  // average memory, read when a sample enters, written at commit
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      avg_mem[ctl.ch] <= avg_new;
    end
    if (ctl.rd_en) begin
      avg_rd_r <= avg_mem[ctl.ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      ld_r     <= 1'b0;
    end else begin
      if (ctl.clear) begin
        loaded_r <= '0;
      end else if (ctl.wr_en) begin
        loaded_r[ctl.ch] <= 1'b1;
      end
      if (ctl.rd_en) begin
        ld_r <= loaded_r[ctl.ch];
      end
    end
  end

  // weighted products; the new median term has no fraction bits
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_new_r <= NewW'(alpha_eff) * NewW'(median);
      p_old_r <= OldW'(alpha_inv) * OldW'(avg_rd_r);
    end
  end

  // round half up on the old term, then add
  assign old_rnd = p_old_r + OldW'(1 << (FracW - 1));
  assign blend   = (NewW + 1)'(p_new_r) + (NewW + 1)'(old_rnd[OldW-1:FracW]);
  assign avg_new = ld_r ? AvgW'(blend) : AvgW'({median, {FracW{1'b0}}});

endmodule

`default_nettype wire

[hw/rtl/median_ema_sample_filter_core.sv]
`default_nettype none

// Two-channel sample filter: running upper median over a ring window per
// channel, followed by a per-channel exponential moving average.
// in_if carries transactions of kind, channel and a 12-bit sample code. A
// sample transaction writes the code into its channel's window and yields one
// out_if transaction with the channel, the window median and the Q12.16
// average. A restart transaction empties both averages and yields nothing.
// The APB port holds ema_alpha (Q1.16, values above 1.0 act as 1.0) at
// byte address 0; pready is always high.
// A sample walks the window memory one entry per cycle into the insertion
// sorter (S_READ), lets the last read land (S_DRAIN), forms the weighted
// products (S_MUL), then adds them into the output register (S_COMMIT).
// One sample is worked on at a time, so a new transaction is accepted only
// in S_IDLE; a restart is taken in S_IDLE and leaves the block idle.
// A finished result sits in the output register; if the receiver stalls, the
// next sample is still accepted and worked on, and waits in its last step
// until the output register frees.
// Synchronous reset empties windows and averages, clears write slots and
// loads ema_alpha with 6554.
module median_ema_sample_filter_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mesf_in_if.sink                            in_if,
  mesf_out_if.source                         out_if,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mesf_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [mesf_pkg::CfgDataW-1:0] pwdata,
  output logic [mesf_pkg::CfgDataW-1:0]      prdata,
  output logic                               pready
);
  import mesf_pkg::*;

  state_t           state_r, state_nxt;
  logic [SlotW-1:0] rd_idx_r, rd_idx_nxt;
  logic [SlotW-1:0] slot_r [NumCh];
  logic             ch_r;
  logic [AlphaW-1:0] alpha_r;

  logic             out_vld_r;
  logic             out_ch_r;
  logic [CodeW-1:0] out_med_r;
  logic [AvgW-1:0]  out_filt_r;

  logic             accept;
  logic             sample_acc;
  logic             restart_acc;
  logic             commit;
  logic             cfg_wr;

  win_ctl_t         win_ctl;
  sort_ctl_t        sort_ctl;
  ema_ctl_t         ema_ctl;
  logic             win_rd_vld;
  logic [CodeW-1:0] win_rd_code;
  logic [CodeW-1:0] median;
  logic [AvgW-1:0]  avg_new;

  // input handshake
  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign sample_acc  = accept && (in_if.kind == KIND_SAMPLE);
  assign restart_acc = accept && (in_if.kind == KIND_RESTART);
  assign commit      = (state_r == S_COMMIT) && (!out_vld_r || out_if.ready);

  // sequencer: next state
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (sample_acc) begin
          state_nxt  = S_READ;
          rd_idx_nxt = '0;
        end
      end
      S_READ: begin
        if (rd_idx_r == LastIdx) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      S_DRAIN:  state_nxt = S_MUL;
      S_MUL:    state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // per-channel write slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NumCh; c++) begin
        slot_r[c] <= '0;
      end
      ch_r <= 1'b0;
    end else if (sample_acc) begin
      ch_r <= in_if.channel;
      slot_r[in_if.channel] <= (slot_r[in_if.channel] == LastIdx) ? '0 :
                               slot_r[in_if.channel] + 1'b1;
    end
  end

  // window memory control
  always_comb begin
    win_ctl.wr_en   = sample_acc;
    win_ctl.wr_addr = win_addr(in_if.channel, slot_r[in_if.channel]);
    win_ctl.wr_data = in_if.sample_code;
    win_ctl.rd_en   = (state_r == S_READ);
    win_ctl.rd_addr = win_addr(ch_r, rd_idx_r);
  end

  assign sort_ctl.clr = sample_acc;
  assign sort_ctl.ins = win_rd_vld;

  // average control
  always_comb begin
    ema_ctl.rd_en  = sample_acc;
    ema_ctl.clear  = restart_acc;
    ema_ctl.mul_en = (state_r == S_MUL);
    ema_ctl.wr_en  = commit;
    ema_ctl.ch     = (state_r == S_IDLE) ? in_if.channel : ch_r;
  end

  mesf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .rd_vld  (win_rd_vld),
    .rd_code (win_rd_code)
  );

  mesf_sorter u_sorter (
    .clk    (clk),
    .ctl    (sort_ctl),
    .code   (win_rd_code),
    .median (median)
  );

  mesf_ema u_ema (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ema_ctl),
    .alpha   (alpha_r),
    .median  (median),
    .avg_new (avg_new)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (commit) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch_r   <= ch_r;
      out_med_r  <= median;
      out_filt_r <= avg_new;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.out_channel    = out_ch_r;
  assign out_if.median_code    = out_med_r;
  assign out_if.filtered_value = out_filt_r;

  // configuration register
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= AlphaReset;
    end else if (cfg_wr && (paddr[2] == REG_EMA_ALPHA)) begin
      alpha_r <= pwdata[AlphaW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_EMA_ALPHA) ? CfgDataW'(alpha_r) : '0;
  assign pready = 1'b1;

  // checks
  a_rd_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (rd_idx_r <= LastIdx))
    else $error("window read index past end of window");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r[0] <= LastIdx) && (slot_r[1] <= LastIdx))
    else $error("write slot past end of window");

  a_sample_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> (state_r == S_READ) && (rd_idx_r == '0))
    else $error("accepted sample did not start the window walk");

  a_filt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_filt_r <= AvgMax))
    else $error("filtered value above largest code");

endmodule

`default_nettype wire

[tb/sv/median_ema_sample_filter_core_tb.sv]
`timescale 1ns / 100ps

module median_ema_sample_filter_core_tb;
  import mesf_pkg::*;

  typedef struct packed {
    logic             ch;
    logic [CodeW-1:0] median;
    logic [AvgW-1:0]  average;
  } filt_result_t;

  localparam logic [CfgAddrW-1:0] ALPHA_ADDR = CfgAddrW'({REG_EMA_ALPHA, 2'b00});
  localparam int DRAIN_CYCLES = WINDOW + 12;
  localparam int LONG_HOLD    = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  mesf_in_if  in_if ();
  mesf_out_if out_if ();

  median_ema_sample_filter_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // filter state as the block should hold it
  logic [CodeW-1:0]  win_codes [NumCh][WINDOW];
  int unsigned       next_slot [NumCh];
  logic [AvgW-1:0]   avg_model [NumCh];
  bit                ema_loaded [NumCh];
  logic [AlphaW-1:0] alpha_setting;

  filt_result_t      pending_results [$];
  logic [CodeW-1:0]  stream_base [NumCh];
  int                fail_count;
  int                results_checked;
  int                samples_sent;
  int                restarts_sent;
  int                alpha_writes;
  bit                send_gaps_on;
  bit                recv_stalls_on;
  bit                long_hold_req;

  function automatic void reset_filter_model();
    for (int c = 0; c < NumCh; c++) begin
      for (int i = 0; i < WINDOW; i++) win_codes[c][i] = '0;
      next_slot[c]  = 0;
      avg_model[c]  = '0;
      ema_loaded[c] = 1'b0;
    end
    alpha_setting = AlphaReset;
  endfunction

  // upper median of one channel's ring window
  function automatic logic [CodeW-1:0] window_median(input logic ch);
    int sorted_codes [$];
    sorted_codes = {};
    for (int i = 0; i < WINDOW; i++) sorted_codes.push_back(int'(win_codes[ch][i]));
    sorted_codes.sort();
    return CodeW'(sorted_codes[MedIdx]);
  endfunction

  // update filter state for one accepted transaction, queue the expected result of a sample
  function automatic void predict_filter(input logic kind, input logic ch,
                                         input logic [CodeW-1:0] code);
    logic [63:0]      weight;
    logic [63:0]      acc;
    logic [CodeW-1:0] med;
    filt_result_t     res;
    if (kind == KIND_RESTART) begin
      for (int c = 0; c < NumCh; c++) begin
        avg_model[c]  = '0;
        ema_loaded[c] = 1'b0;
      end
      restarts_sent++;
      return;
    end
    win_codes[ch][next_slot[ch]] = code;
    next_slot[ch] = (next_slot[ch] + 1) % WINDOW;
    med = window_median(ch);
    if (!ema_loaded[ch]) begin
      avg_model[ch]  = AvgW'(med) << FracW;
      ema_loaded[ch] = 1'b1;
    end else begin
      // alpha above one saturates, rounding is half up
      weight = (alpha_setting > AlphaOne) ? 64'(AlphaOne) : 64'(alpha_setting);
      acc = weight * (64'(med) << FracW) + (64'(AlphaOne) - weight) * 64'(avg_model[ch])
            + (64'd1 << (FracW - 1));
      avg_model[ch] = AvgW'(acc >> FracW);
    end
    res.ch      = ch;
    res.median  = med;
    res.average = avg_model[ch];
    pending_results.push_back(res);
    samples_sent++;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // one transaction on the sample channel, with an optional gap ahead of it
  task automatic send_item(input logic kind, input logic ch, input logic [CodeW-1:0] code);
    int gap;
    gap = 0;
    if (send_gaps_on && $urandom_range(0, 99) >= 55) gap = pick_gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.channel     <= ch;
    in_if.sample_code <= code;
    do @(posedge clk); while (!in_if.ready);
    predict_filter(kind, ch, code);
  endtask

  task automatic send_random_item(input int restart_pct);
    int               r;
    logic             ch;
    logic [CodeW-1:0] code;
    r  = $urandom_range(0, 99);
    ch = 1'($urandom_range(0, 1));
    if (r < restart_pct) begin
      send_item(KIND_RESTART, ch, CodeW'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 35) begin
      code = CodeW'($urandom);
    end else if (r < 75) begin
      // noisy readings around a steady level
      code = stream_base[ch] + CodeW'($urandom_range(0, 63)) - CodeW'(32);
    end else if (r < 85) begin
      code = r[0] ? '1 : '0;
    end else begin
      stream_base[ch] = CodeW'($urandom);
      code = stream_base[ch];
    end
    send_item(KIND_SAMPLE, ch, code);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // a restart gives no result, so let the block settle before touching the register
  task automatic wait_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write alpha, then read it back
  task automatic set_alpha(input logic [AlphaW-1:0] value,
                           input logic [CfgDataW-AlphaW-1:0] upper);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ALPHA_ADDR;
    pwdata  <= {upper, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    alpha_setting = value;
    alpha_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("ema_alpha readback", CfgDataW'(value), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // zeros from reset take part in the median until the window fills
  task automatic test_window_fill();
    send_item(KIND_SAMPLE, 1'b0, '1);
    send_item(KIND_SAMPLE, 1'b0, '1);
    send_item(KIND_SAMPLE, 1'b0, '1);
    send_item(KIND_SAMPLE, 1'b1, '0);
    send_item(KIND_SAMPLE, 1'b0, 12'hAAA);
    send_item(KIND_SAMPLE, 1'b0, 12'h555);
    send_item(KIND_SAMPLE, 1'b1, 12'h001);
    send_item(KIND_SAMPLE, 1'b0, '1);
    send_item(KIND_SAMPLE, 1'b1, 12'h800);
  endtask

  // restart empties both averages, the next sample loads directly
  task automatic test_restart_reload();
    send_item(KIND_RESTART, 1'b1, '1);
    send_item(KIND_SAMPLE, 1'b0, 12'h800);
    send_item(KIND_SAMPLE, 1'b1, 12'h7FF);
    send_item(KIND_RESTART, 1'b0, '0);
    send_item(KIND_SAMPLE, 1'b0, 12'h001);
  endtask

  // alpha of zero, exactly one, and above one
  task automatic test_alpha_extremes();
    set_alpha('0, '0);
    send_item(KIND_SAMPLE, 1'b0, '1);
    send_item(KIND_SAMPLE, 1'b0, '0);
    set_alpha(AlphaOne, '1);
    send_item(KIND_SAMPLE, 1'b0, '1);
    send_item(KIND_SAMPLE, 1'b1, '1);
    set_alpha('1, '0);
    send_item(KIND_SAMPLE, 1'b0, '0);
    set_alpha(AlphaOne + 1'b1, (CfgDataW-AlphaW)'($urandom));
    send_item(KIND_SAMPLE, 1'b1, 12'h003);
  endtask

  // several alpha settings, random idling on both sides
  task automatic test_random_traffic();
    logic [AlphaW-1:0] alpha_plan [7];
    alpha_plan[0] = AlphaReset;
    alpha_plan[1] = AlphaW'(1);
    alpha_plan[2] = AlphaW'($urandom_range(1, 65535));
    alpha_plan[3] = AlphaW'(32768);
    alpha_plan[4] = AlphaW'(65535);
    alpha_plan[5] = AlphaW'($urandom_range(1, 65535));
    alpha_plan[6] = AlphaW'($urandom_range(65537, 131071));
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    for (int p = 0; p < 7; p++) begin
      set_alpha(alpha_plan[p], (CfgDataW-AlphaW)'($urandom));
      repeat (240) send_random_item(4);
    end
  endtask

  // receiver holds off while samples keep coming, so the input backs up
  task automatic test_long_hold();
    send_gaps_on  = 1'b0;
    long_hold_req = 1'b1;
    repeat (12) send_random_item(0);
    send_gaps_on  = 1'b1;
  endtask

  // back to back transactions with the receiver always ready
  task automatic test_no_idle();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (100) send_random_item(3);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (20) send_random_item(5);
    wait_drained();
    repeat (20) send_random_item(5);
  endtask

  // receiver side ready pattern
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (recv_stalls_on && $urandom_range(0, 99) < 25) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap_len()) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    filt_result_t head;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: channel %0d median %0d average %0d", $time,
                 out_if.out_channel, out_if.median_code, out_if.filtered_value);
        fail_count++;
      end else begin
        head = pending_results.pop_front();
        check_field("out_channel", 32'(head.ch), 32'(out_if.out_channel));
        check_field("median_code", 32'(head.median), 32'(out_if.median_code));
        check_field("filtered_value", 32'(head.average), 32'(out_if.filtered_value));
        results_checked++;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("median_ema_sample_filter_core_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_SAMPLE;
    in_if.channel     = 1'b0;
    in_if.sample_code = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    fail_count        = 0;
    results_checked   = 0;
    samples_sent      = 0;
    restarts_sent     = 0;
    alpha_writes      = 0;
    send_gaps_on      = 1'b1;
    recv_stalls_on    = 1'b1;
    long_hold_req     = 1'b0;
    stream_base[0]    = CodeW'($urandom);
    stream_base[1]    = CodeW'($urandom);
    reset_filter_model();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_window_fill();
    test_restart_reload();
    test_alpha_extremes();
    test_random_traffic();
    test_long_hold();
    test_no_idle();
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples and %0d restarts, checked %0d filtered results",
             samples_sent, restarts_sent, results_checked);
    $display("%0d alpha writes incl. zero, one and saturating values, with long output stalls",
             alpha_writes);
    if (fail_count == 0) begin
      $display("median_ema_sample_filter_core_tb: PASS");
    end else begin
      $display("median_ema_sample_filter_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mesf_pkg.sv
hw/rtl/mesf_if.sv
hw/rtl/mesf_window.sv
hw/rtl/mesf_sorter.sv
hw/rtl/mesf_ema.sv
hw/rtl/median_ema_sample_filter_core.sv
tb/sv/median_ema_sample_filter_core_tb.sv
